// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the request parser, used by its top level.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define MRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define MRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== rtl/mrp_pkg.sv =====
// Package for the Modbus RTU request parser: phase codes, function codes,
// register indexes, reset values, result type and the CRC-16 byte update.
package mrp_pkg;

    typedef enum logic [3:0] {
        PH_ADDR   = 4'd0,
        PH_FUNC   = 4'd1,
        PH_REG_HI = 4'd2,
        PH_REG_LO = 4'd3,
        PH_VAL_HI = 4'd4,
        PH_VAL_LO = 4'd5,
        PH_CNT_HI = 4'd6,
        PH_CNT_LO = 4'd7,
        PH_CRC_LO = 4'd8,
        PH_CRC_HI = 4'd9
    } t_phase;

    localparam logic [7:0]  FN_READ       = 8'h03;
    localparam logic [7:0]  FN_WRITE      = 8'h06;
    localparam logic [7:0]  STATION_RESET = 8'h0A;
    localparam logic [7:0]  HIGHEST_RESET = 8'd3;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    localparam logic CFG_STATION = 1'b0;
    localparam logic CFG_HIGHEST = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] register_index;
        logic [7:0] write_value;
        logic [7:0] read_count;
    } t_result;

    // One byte through CRC-16/MODBUS, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/mrp_in_reg.sv =====
// Input register for received bytes: one beat of storage.
// Depends on nothing outside this file.
module mrp_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       w_load;

    // Hold the beat until the parser takes it.
    assign o_stall = r_valid && !i_take;
    assign w_load  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== rtl/mrp_parser.sv =====
// Frame parser: configuration registers, phase state, header CRC and
// field checks for one byte per cycle while i_go is high. Depends on mrp_pkg.
module mrp_parser
    import mrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_go,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [7:0]  r_station;
    logic [7:0]  r_highest;
    t_phase      r_phase;
    t_phase      n_phase;
    logic        r_is_write;
    logic        n_is_write;
    logic [7:0]  r_held_reg;
    logic [7:0]  n_held_reg;
    logic [7:0]  r_held_op;
    logic [7:0]  n_held_op;
    logic [15:0] r_crc;
    logic [15:0] n_crc;

    logic [15:0] w_crc_step;
    logic [15:0] w_crc_addr;
    logic [9:0]  w_cnt_end;
    logic [9:0]  w_cnt_lim;
    logic        w_ok;

    assign w_crc_step = crc_byte(r_crc, i_byte);
    assign w_crc_addr = crc_byte(CRC_INIT, i_byte);
    // count + register <= highest + 1
    assign w_cnt_end  = {2'b00, i_byte} + {2'b00, r_held_reg};
    assign w_cnt_lim  = {2'b00, r_highest} + 10'd1;

    // Next state
    always_comb begin
        n_phase    = r_phase;
        n_is_write = r_is_write;
        n_held_reg = r_held_reg;
        n_held_op  = r_held_op;
        n_crc      = r_crc;
        w_ok       = 1'b0;

        case (r_phase)
            PH_FUNC: begin
                if (i_byte == FN_READ || i_byte == FN_WRITE) begin
                    n_is_write = (i_byte == FN_WRITE);
                    n_phase    = PH_REG_HI;
                    w_ok       = 1'b1;
                end
            end
            PH_REG_HI: begin
                if (i_byte == 8'h00) begin
                    n_phase = PH_REG_LO;
                    w_ok    = 1'b1;
                end
            end
            PH_REG_LO: begin
                if (i_byte <= r_highest) begin
                    n_held_reg = i_byte;
                    n_phase    = r_is_write ? PH_VAL_HI : PH_CNT_HI;
                    w_ok       = 1'b1;
                end
            end
            PH_VAL_HI: begin
                if (i_byte == 8'h00) begin
                    n_phase = PH_VAL_LO;
                    w_ok    = 1'b1;
                end
            end
            PH_VAL_LO: begin
                n_held_op = i_byte;
                n_phase   = PH_CRC_LO;
                w_ok      = 1'b1;
            end
            PH_CNT_HI: begin
                if (i_byte == 8'h00) begin
                    n_phase = PH_CNT_LO;
                    w_ok    = 1'b1;
                end
            end
            PH_CNT_LO: begin
                if (i_byte != 8'h00 && w_cnt_end <= w_cnt_lim) begin
                    n_held_op = i_byte;
                    n_phase   = PH_CRC_LO;
                    w_ok      = 1'b1;
                end
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase

        if (r_phase == PH_CRC_LO && i_byte == r_crc[7:0]) begin
            // CRC low byte matched: advance, CRC stays
            n_phase = PH_CRC_HI;
        end else if (r_phase == PH_CRC_HI && i_byte == r_crc[15:8]) begin
            n_phase = PH_ADDR;
            n_crc   = CRC_INIT;
        end else if (w_ok) begin
            n_crc = w_crc_step;
        end else if (i_byte == r_station) begin
            // Mismatch: take this byte as a fresh address
            n_phase = PH_FUNC;
            n_crc   = w_crc_addr;
        end else begin
            n_phase = PH_ADDR;
            n_crc   = CRC_INIT;
        end
    end

    // Outputs
    always_comb begin
        o_res_valid          = i_go && r_phase == PH_CRC_HI && i_byte == r_crc[15:8];
        o_res.kind           = r_is_write;
        o_res.register_index = r_held_reg;
        o_res.write_value    = r_is_write ? r_held_op : 8'h00;
        o_res.read_count     = r_is_write ? 8'h00 : r_held_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station  <= STATION_RESET;
            r_highest  <= HIGHEST_RESET;
            r_phase    <= PH_ADDR;
            r_is_write <= 1'b0;
            r_held_reg <= 8'h00;
            r_held_op  <= 8'h00;
            r_crc      <= CRC_INIT;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_STATION: r_station <= i_cfg_data;
                    CFG_HIGHEST: r_highest <= i_cfg_data;
                    default:     r_station <= r_station;
                endcase
            end
            if (i_go) begin
                r_phase    <= n_phase;
                r_is_write <= n_is_write;
                r_held_reg <= n_held_reg;
                r_held_op  <= n_held_op;
                r_crc      <= n_crc;
            end
        end
    end

endmodule

// ===== rtl/mrp_out_reg.sv =====
// Result register for decoded requests: one beat of storage.
// Depends on mrp_pkg for the result type.
module mrp_out_reg
    import mrp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // Free when empty or when the held beat leaves this cycle.
    assign o_ready = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== rtl/modbus_rtu_request_parser_unit.sv =====
// Top level of the Modbus RTU request parser: input register, parser, result register.
// Depends on mrp_pkg, mrp_in_reg, mrp_parser, mrp_out_reg and assert_macros.svh.
//
//   channel  direction  handshake                  payload
//   in       to block   i_in_valid / o_in_stall    i_rx_byte
//   out      from block o_out_valid / i_out_stall  o_kind, o_register_index,
//                                                  o_write_value, o_read_count
//   cfg      to block   i_cfg_we                   i_cfg_index, i_cfg_data
//
// One byte per cycle while the result register can take a beat. A byte is held in
// the input register, and its result, if any, is loaded into the result register
// when the parser steps on that byte; o_out_valid comes from the result register.
// The parser step (eight-round CRC-16 byte update plus field compares) is the one
// register-to-register path.
// Reset is synchronous, active low; config returns to station 0x0A, highest register 3.
// A stalled result blocks the parser; the input register still takes one more beat.
`include "assert_macros.svh"

module modbus_rtu_request_parser_unit
    import mrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_kind,
    output logic [7:0] o_register_index,
    output logic [7:0] o_write_value,
    output logic [7:0] o_read_count
);

    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_out_ready;
    logic       w_take;
    logic       w_res_valid;
    t_result    w_res;
    t_result    w_out_res;

    // Step the parser whenever a byte is held and the result slot can take a beat.
    assign w_take = w_in_valid && w_out_ready;

    mrp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_byte  (i_rx_byte),
        .i_take  (w_take),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    mrp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_go        (w_take),
        .i_byte      (w_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    mrp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .o_ready (w_out_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (w_out_res)
    );

    assign o_kind           = w_out_res.kind;
    assign o_register_index = w_out_res.register_index;
    assign o_write_value    = w_out_res.write_value;
    assign o_read_count     = w_out_res.read_count;

    // A write carries no count; a read carries a nonzero count and no value.
    `MRP_ASSERT_NOW(a_result_shape, i_clk, i_rst_n, o_out_valid, (o_kind ? (o_read_count == 8'h00) : (o_write_value == 8'h00 && o_read_count != 8'h00)))
    // A decoded request always lands in the result register.
    `MRP_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, w_take && w_res_valid, o_out_valid)
    // A held byte that the parser did not take is still held.
    `MRP_ASSERT_NEXT(a_byte_kept, i_clk, i_rst_n, w_in_valid && !w_take, w_in_valid)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for modbus_rtu_request_parser_unit: random and directed
// byte streams against an in-bench request decoder. Depends on mrp_pkg and the RTL.
module tb;
    import mrp_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 4;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_BYTES    = 90;

    typedef logic [7:0] t_frame [8];

    // Drive every block input to a known value from time zero.
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_index = CFG_STATION;
    logic [7:0] cfg_data  = 8'h00;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic       kind;
    logic [7:0] register_index;
    logic [7:0] write_value;
    logic [7:0] read_count;

    // Bench copy of the configuration registers.
    logic [7:0] cfg_station = STATION_RESET;
    logic [7:0] cfg_highest = HIGHEST_RESET;

    // Bench copy of the parser state.
    t_phase      rx_phase    = PH_ADDR;
    logic        rx_is_write = 1'b0;
    logic [7:0]  rx_register = 8'h00;
    logic [7:0]  rx_operand  = 8'h00;
    logic [15:0] rx_crc      = CRC_INIT;

    logic [7:0] rx_stream[$];          // bytes waiting to be offered
    t_result    decoded_requests[$];   // requests the block still owes us

    int   send_gap      = 0;
    int   stall_left    = 0;
    int   hold_left     = 0;
    int   quiet_cycles  = 0;
    int   mismatch_count = 0;
    int   long_hold_reqs  = 0;         // bumped by the sequence to ask for a hold
    int   long_hold_done  = 0;         // requests the receiver has started
    logic sender_steady   = 1'b0;
    logic receiver_steady = 1'b0;

    modbus_rtu_request_parser_unit dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_rx_byte        (rx_byte),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_kind           (kind),
        .o_register_index (register_index),
        .o_write_value    (write_value),
        .o_read_count     (read_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // CRC-16/MODBUS, one byte, LSB first.
    function automatic logic [15:0] crc16_modbus(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        repeat (8) begin
            crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
        end
        return crc;
    endfunction

    // Advance the bench parser by one received byte; queue a request when a
    // frame closes with a matching CRC.
    function automatic void parse_rx_byte(input logic [7:0] b);
        logic    take;
        int      lim;
        t_result req;
        take = 1'b0;
        case (rx_phase)
            PH_FUNC: begin
                if (b == FN_READ || b == FN_WRITE) begin
                    rx_is_write = (b == FN_WRITE);
                    rx_phase    = PH_REG_HI;
                    take        = 1'b1;
                end
            end
            PH_REG_HI: begin
                if (b == 8'h00) begin
                    rx_phase = PH_REG_LO;
                    take     = 1'b1;
                end
            end
            PH_REG_LO: begin
                // Check against the highest register as it stands now.
                if (b <= cfg_highest) begin
                    rx_register = b;
                    rx_phase    = rx_is_write ? PH_VAL_HI : PH_CNT_HI;
                    take        = 1'b1;
                end
            end
            PH_VAL_HI: begin
                if (b == 8'h00) begin
                    rx_phase = PH_VAL_LO;
                    take     = 1'b1;
                end
            end
            PH_VAL_LO: begin
                rx_operand = b;
                rx_phase   = PH_CRC_LO;
                take       = 1'b1;
            end
            PH_CNT_HI: begin
                if (b == 8'h00) begin
                    rx_phase = PH_CNT_LO;
                    take     = 1'b1;
                end
            end
            PH_CNT_LO: begin
                // A lowered highest register can leave no legal count at all.
                lim = int'(cfg_highest) + 1 - int'(rx_register);
                if (b != 8'h00 && int'(b) <= lim) begin
                    rx_operand = b;
                    rx_phase   = PH_CRC_LO;
                    take       = 1'b1;
                end
            end
            PH_CRC_LO: begin
                if (b == rx_crc[7:0]) begin
                    rx_phase = PH_CRC_HI;
                    return;
                end
            end
            PH_CRC_HI: begin
                if (b == rx_crc[15:8]) begin
                    req.kind           = rx_is_write;
                    req.register_index = rx_register;
                    req.write_value    = rx_is_write ? rx_operand : 8'h00;
                    req.read_count     = rx_is_write ? 8'h00 : rx_operand;
                    decoded_requests.push_back(req);
                    rx_phase = PH_ADDR;
                    rx_crc   = CRC_INIT;
                    return;
                end
            end
            default: ;
        endcase
        if (take) begin
            rx_crc = crc16_modbus(rx_crc, b);
        end else if (b == cfg_station) begin
            // A rejected byte gets a second look as the start of a new frame.
            rx_crc   = crc16_modbus(CRC_INIT, b);
            rx_phase = PH_FUNC;
        end else begin
            rx_crc   = CRC_INIT;
            rx_phase = PH_ADDR;
        end
    endfunction

    // Assemble a complete request frame for the current station, CRC low byte first.
    function automatic t_frame build_frame(input logic wr, input logic [7:0] reg_lo,
                                           input logic [7:0] operand);
        t_frame      f;
        logic [15:0] crc;
        f[0] = cfg_station;
        f[1] = wr ? FN_WRITE : FN_READ;
        f[2] = 8'h00;
        f[3] = reg_lo;
        f[4] = 8'h00;
        f[5] = operand;
        crc  = CRC_INIT;
        for (int i = 0; i < 6; i++) begin
            crc = crc16_modbus(crc, f[i]);
        end
        f[6] = crc[7:0];
        f[7] = crc[15:8];
        return f;
    endfunction

    // Well-formed request with random content; lean on the range edges.
    function automatic t_frame random_request();
        logic       wr;
        logic [7:0] reg_lo;
        logic [7:0] operand;
        int         max_count;
        wr = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0:       reg_lo = 8'h00;
            1:       reg_lo = cfg_highest;
            default: reg_lo = 8'($urandom_range(0, cfg_highest));
        endcase
        max_count = int'(cfg_highest) + 1 - int'(reg_lo);
        if (wr) begin
            operand = 8'($urandom_range(0, 255));
        end else begin
            case ($urandom_range(0, 3))
                0:       operand = 8'd1;
                1:       operand = 8'(max_count);
                default: operand = 8'($urandom_range(1, max_count));
            endcase
        end
        return build_frame(wr, reg_lo, operand);
    endfunction

    function automatic void queue_frame(input t_frame f, input int keep);
        for (int i = 0; i < keep; i++) begin
            rx_stream.push_back(f[i]);
        end
    endfunction

    // Fill the byte queue with one phase worth of traffic: mostly requests,
    // some damaged, some cut short, some line noise; clean_only sends only clean requests.
    function automatic void queue_traffic(input int n_bytes, input logic clean_only);
        t_frame f;
        int     pushed;
        int     pick;
        pushed = 0;
        while (pushed < n_bytes) begin
            f    = random_request();
            pick = clean_only ? 0 : $urandom_range(0, 9);
            case (pick)
                7: begin
                    // Line noise.
                    repeat ($urandom_range(1, 4)) begin
                        rx_stream.push_back(8'($urandom_range(0, 255)));
                        pushed++;
                    end
                end
                8: begin
                    // Stray address byte ahead of a frame: forces a restart.
                    rx_stream.push_back(cfg_station);
                    queue_frame(f, 8);
                    pushed += 9;
                end
                9: begin
                    // Frame cut short, next one runs into it.
                    pick = $urandom_range(1, 7);
                    queue_frame(f, pick);
                    pushed += pick;
                end
                default: begin
                    if (!clean_only && $urandom_range(0, 3) == 0) begin
                        pick    = $urandom_range(0, 7);
                        f[pick] = f[pick] ^ 8'($urandom_range(1, 255));
                    end
                    queue_frame(f, 8);
                    pushed += 8;
                end
            endcase
        end
        // Sometimes leave a frame half sent so the next settings land mid-frame.
        if (!clean_only && $urandom_range(0, 1) == 1) begin
            queue_frame(random_request(), $urandom_range(1, 7));
        end
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return 0;
        end else if (r < 9) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic int stall_stretch();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    task automatic note_mismatch(input string what);
        $display("%0t ns: request check: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            note_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
        end
    endtask

    // Write both registers; only called with the block idle.
    task automatic apply_settings(input logic [7:0] station, input logic [7:0] highest);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_STATION;
        cfg_data  <= station;
        @(posedge clk);
        cfg_index <= CFG_HIGHEST;
        cfg_data  <= highest;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_station = station;
        cfg_highest = highest;
    endtask

    // Hold until every byte is in and every request is out, then let the
    // pipeline settle in case the last beats were still being parsed.
    task automatic wait_until_drained();
        do @(posedge clk);
        while (rx_stream.size() != 0 || in_valid || decoded_requests.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Byte driver: predict on each accepted beat, then offer the next byte.
    // A stalled byte is held untouched.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            rx_byte  <= 8'h00;
            send_gap <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                parse_rx_byte(rx_byte);
            end
            if (!in_valid || !in_stall) begin
                if (send_gap != 0) begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (rx_stream.size() != 0) begin
                    in_valid <= 1'b1;
                    rx_byte  <= rx_stream.pop_front();
                    send_gap <= sender_steady ? 0 : sender_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side back-pressure: random stalls, steady stretches, and one long hold.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (long_hold_done != long_hold_reqs) begin
            out_stall      <= 1'b1;
            hold_left      <= LONG_HOLD;
            long_hold_done <= long_hold_reqs;
        end else if (receiver_steady) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_stretch();
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Request monitor: compare each accepted result beat with the oldest prediction.
    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (decoded_requests.size() == 0) begin
                note_mismatch($sformatf("unexpected request kind=%0d reg=%0d val=%0d cnt=%0d",
                                        kind, register_index, write_value, read_count));
            end else begin
                want = decoded_requests.pop_front();
                check_field("kind", {7'd0, kind}, {7'd0, want.kind});
                check_field("register_index", register_index, want.register_index);
                check_field("write_value", write_value, want.write_value);
                check_field("read_count", read_count, want.read_count);
            end
        end
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset settings: stray address before a read,
        // the widest legal read, a write to the top register with an all-ones
        // value, and both byte extremes as noise.
        rx_stream.push_back(cfg_station);
        queue_frame(build_frame(1'b0, 8'd0, 8'd1), 8);
        queue_frame(build_frame(1'b0, 8'd0, cfg_highest + 8'd1), 8);
        queue_frame(build_frame(1'b1, cfg_highest, 8'hFF), 8);
        rx_stream.push_back(8'hFF);
        rx_stream.push_back(8'h00);
        wait_until_drained();

        for (int p = 1; p <= 8; p++) begin
            case (p)
                1:       apply_settings(8'h00, 8'd0);
                2:       apply_settings(8'hFF, 8'd254);
                4:       apply_settings(STATION_RESET, 8'd254);
                5:       apply_settings(8'($urandom_range(0, 255)), 8'd1);
                7:       apply_settings(FN_WRITE, 8'($urandom_range(0, 254)));
                default: apply_settings(8'($urandom_range(0, 255)),
                                        8'($urandom_range(0, 254)));
            endcase
            sender_steady   <= (p == 4 || p == 6);
            receiver_steady <= (p == 6);
            if (p == 4) begin
                // Hold results back while clean frames keep coming, so the
                // block backs up and stalls its input.
                long_hold_reqs <= long_hold_reqs + 1;
                queue_traffic(PHASE_BYTES, 1'b1);
            end else begin
                queue_traffic(PHASE_BYTES, 1'b0);
            end
            wait_until_drained();
        end

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
